### rtl/range_argmin_tree_unit_assert.svh
// Assertion macros for the range argmin tree unit checker.
// Each macro samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef RANGE_ARGMIN_TREE_UNIT_ASSERT_SVH
`define RANGE_ARGMIN_TREE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RATU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RATU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ratu_pkg.sv
package ratu_pkg;

	localparam int MAX_POS      = 1024;
	localparam int NODE_AW      = $clog2(2 * MAX_POS);
	localparam int IDX_W        = NODE_AW + 1;
	localparam int POS_W        = 11;
	localparam int VAL_W        = 32;
	localparam int CFG_W        = 11;
	localparam int N_USED_RESET = 1024;
	localparam int S_DATA_W     = ((2 * POS_W + VAL_W + 7) / 8) * 8;
	localparam int M_DATA_W     = ((POS_W + 7) / 8) * 8;

	typedef struct packed {
		logic                    valid;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
	} node_t;

	// One-hot sequencer states
	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_U_RD   = 7'b0000100,
		ST_U_WR   = 7'b0001000,
		ST_Q_STEP = 7'b0010000,
		ST_Q_PL   = 7'b0100000,
		ST_Q_PR   = 7'b1000000
	} state_t;

	// True if a beats b: valid over invalid, then smaller value, then smaller position
	function automatic logic better(node_t a, node_t b);
		logic r;
		if (!a.valid) begin
			r = 1'b0;
		end else if (!b.valid) begin
			r = 1'b1;
		end else if (a.val != b.val) begin
			r = (a.val < b.val);
		end else begin
			r = (a.pos < b.pos);
		end
		return r;
	endfunction

endpackage

### rtl/range_argmin_tree_unit.sv
// Range argmin tree unit: a segment tree of minimum-with-position nodes over positions
// 1..n_used, held in one 2048-entry node memory with a single read and a single write port.
// An item with tuser low is a point update (position, value); it produces no result, and
// an update outside 1..n_used is dropped at once. An item with tuser high is a range query
// over position..range_last, clipped to 1..n_used; it returns one result whose tdata holds
// the position of the smallest value (smallest position on ties) and whose tuser is found.
// An empty span, or one with no written position, returns position 0 with found low.
// One item is worked at a time and s_tready stays low until it is done. An update does
// one read of the sibling node and one compare-and-write of the parent per tree level.
// A query makes up to two node reads per level through the one read port, then loads
// the result register, which holds while an earlier result still waits. The result
// register lets the next item be taken while a result still waits on m_tready.
// After reset a clearing pass writes every node empty, with s_tready low;
// n_used may be written during that pass.
module range_argmin_tree_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ratu_pkg::CFG_W-1:0]    cfg_wdata,   // n_used
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ratu_pkg::S_DATA_W-1:0] s_tdata,     // position, value, range_last, zeros
	input  logic                          s_tuser,     // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ratu_pkg::M_DATA_W-1:0] m_tdata,     // min_position, zeros
	output logic                          m_tuser      // found
);
	import ratu_pkg::*;

	// Sequencer and configuration
	state_t               state_q;
	logic [NODE_AW-1:0]   clr_q;
	logic [CFG_W-1:0]     n_used_q;

	// Node memory and its registered read data
	node_t                mem [2**NODE_AW];
	node_t                rdata_q;
	logic                 mem_we;
	logic [NODE_AW-1:0]   mem_waddr;
	node_t                mem_wdata;
	logic [NODE_AW-1:0]   mem_raddr;

	// Working registers: cur_q is the path node on update and the accumulator on query
	node_t                cur_q;
	logic [NODE_AW-1:0]   idx_q;
	logic [IDX_W-1:0]     l_q;
	logic [IDX_W-1:0]     r_q;

	// Result register
	logic                 m_tvalid_q;
	logic [POS_W-1:0]     m_pos_q;
	logic                 m_found_q;

	// Input decode
	logic [POS_W-1:0]     in_pos;
	logic [VAL_W-1:0]     in_val;
	logic [POS_W-1:0]     in_last;
	logic [CFG_W-1:0]     cnt;
	logic                 upd_ok;
	logic [POS_W-1:0]     q_s;
	logic [POS_W-1:0]     q_e;
	logic                 q_ok;
	logic [NODE_AW-1:0]   leaf_idx;
	node_t                leaf;
	logic                 accept;
	logic                 out_free;

	// Shared compare unit and query walk helpers
	logic                 cand_win;
	node_t                best;
	logic [IDX_W-1:0]     r_dec;
	logic [IDX_W-1:0]     l_inc;
	logic                 q_more;

	assign in_pos  = s_tdata[POS_W-1:0];
	assign in_val  = s_tdata[POS_W+VAL_W-1:POS_W];
	assign in_last = s_tdata[2*POS_W+VAL_W-1:POS_W+VAL_W];

	// Saturate the covered count at the tree size
	assign cnt    = (n_used_q > CFG_W'(MAX_POS)) ? CFG_W'(MAX_POS) : n_used_q;
	assign upd_ok = (in_pos != '0) && (CFG_W'(in_pos) <= cnt);

	// Clip the query span to 1..cnt
	assign q_s  = (in_pos == '0) ? POS_W'(1) : in_pos;
	assign q_e  = (CFG_W'(in_last) > cnt) ? POS_W'(cnt) : in_last;
	assign q_ok = (q_s <= q_e);

	assign leaf_idx  = NODE_AW'(MAX_POS - 1) + NODE_AW'(in_pos);
	assign leaf.valid = 1'b1;
	assign leaf.pos   = in_pos;
	assign leaf.val   = in_val;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// The one compare unit: does the node just read beat the held node?
	assign cand_win = better(rdata_q, cur_q);
	assign best     = cand_win ? rdata_q : cur_q;

	assign r_dec  = r_q - IDX_W'(1);
	assign l_inc  = l_q + IDX_W'(1);
	assign q_more = (l_q < r_q);

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: begin
				if (accept && !s_tuser && upd_ok) begin
					mem_we    = 1'b1;
					mem_waddr = leaf_idx;
					mem_wdata = leaf;
				end
			end
			ST_U_RD: begin
				// sibling of the path node
				mem_raddr = idx_q ^ NODE_AW'(1);
			end
			ST_U_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q >> 1;
				mem_wdata = best;
			end
			ST_Q_STEP: begin
				mem_raddr = l_q[0] ? l_q[NODE_AW-1:0] : r_dec[NODE_AW-1:0];
			end
			ST_Q_PL: begin
				mem_raddr = r_dec[NODE_AW-1:0];
			end
			ST_Q_PR: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			n_used_q   <= CFG_W'(N_USED_RESET);
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				n_used_q <= cfg_wdata;
			end
			// drop the result once taken; a new one below takes precedence
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + NODE_AW'(1);
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser) begin
							state_q <= ST_Q_STEP;
						end else if (upd_ok) begin
							state_q <= ST_U_RD;
						end
					end
				end
				ST_U_RD: begin
					state_q <= ST_U_WR;
				end
				ST_U_WR: begin
					// the root has just been written
					if (idx_q[NODE_AW-1:1] == (NODE_AW-1)'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_U_RD;
					end
				end
				ST_Q_STEP: begin
					if (!q_more) begin
						if (out_free) begin
							m_tvalid_q <= 1'b1;
							state_q    <= ST_IDLE;
						end
					end else if (l_q[0]) begin
						state_q <= ST_Q_PL;
					end else if (r_q[0]) begin
						state_q <= ST_Q_PR;
					end
				end
				ST_Q_PL: begin
					if (r_q[0]) begin
						state_q <= ST_Q_PR;
					end else begin
						state_q <= ST_Q_STEP;
					end
				end
				ST_Q_PR: begin
					state_q <= ST_Q_STEP;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CLEAR: begin
			end
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser) begin
						cur_q <= '0;
						if (q_ok) begin
							l_q <= IDX_W'(MAX_POS - 1) + IDX_W'(q_s);
							r_q <= IDX_W'(MAX_POS) + IDX_W'(q_e);
						end else begin
							l_q <= '0;
							r_q <= '0;
						end
					end else begin
						cur_q <= leaf;
						idx_q <= leaf_idx;
					end
				end
			end
			ST_U_RD: begin
			end
			ST_U_WR: begin
				cur_q <= best;
				idx_q <= idx_q >> 1;
			end
			ST_Q_STEP: begin
				if (!q_more) begin
					if (out_free) begin
						m_pos_q   <= cur_q.valid ? cur_q.pos : '0;
						m_found_q <= cur_q.valid;
					end
				end else if (l_q[0]) begin
					// hold l; the left node read is in flight
				end else if (r_q[0]) begin
					r_q <= r_dec;
				end else begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			end
			ST_Q_PL: begin
				cur_q <= best;
				if (r_q[0]) begin
					l_q <= l_inc;
					r_q <= r_dec;
				end else begin
					l_q <= l_inc >> 1;
					r_q <= r_q >> 1;
				end
			end
			ST_Q_PR: begin
				cur_q <= best;
				l_q   <= l_q >> 1;
				r_q   <= r_q >> 1;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(m_pos_q);
	assign m_tuser  = m_found_q;

endmodule

### rtl/ratu_checker.sv
module ratu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [ratu_pkg::S_DATA_W-1:0] s_tdata,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ratu_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tuser
);
	import ratu_pkg::*;

	`include "range_argmin_tree_unit_assert.svh"

	// a stalled result holds
	`RATU_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// no find means position zero
	`RATU_ASSERT_IMP(a_none_zero, m_tvalid && !m_tuser, m_tdata[POS_W-1:0] == '0, "position set without a find")

	// a find names a real position
	`RATU_ASSERT_IMP(a_found_range, m_tvalid && m_tuser, (m_tdata[POS_W-1:0] != '0) && (m_tdata[POS_W-1:0] <= POS_W'(MAX_POS)), "found position out of range")

	// a query keeps the block busy for at least the next cycle
	`RATU_ASSERT_NXT(a_query_busy, s_tvalid && s_tready && s_tuser && (s_tdata != '1 || s_tdata == '1), !s_tready, "ready straight after a query")

	// padding above the position stays clear
	`RATU_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[M_DATA_W-1:POS_W] == '0, "padding bits set")

endmodule

bind range_argmin_tree_unit ratu_checker u_ratu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
